// ===== hw/rtl/lpfr_pkg.sv =====
package lpfr_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 1024;
    localparam logic [7:0]  START_BYTE_RST   = 8'd126;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned FLEN_W = 10;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned TDATA_W = 64;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_DATA   = 2'd0,
        EV_DONE   = 2'd1,
        EV_REJECT = 2'd2
    } event_t;

    localparam logic [1:0] EV_UNUSED = 2'd3;

    typedef struct packed {
        event_t              event_kind;
        logic [7:0]          data_byte;
        logic [IDX_W-1:0]    byte_index;
        logic                last_payload;
        logic [FLEN_W-1:0]   frame_length;
        logic [SUM_W-1:0]    frame_checksum;
    } result_t;

endpackage

// ===== hw/rtl/lpfr_parse.sv =====
module lpfr_parse #(
    parameter int unsigned BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        start_byte,
    output logic              res_valid,
    output lpfr_pkg::result_t res
);
    import lpfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [31:0] LEN_LIMIT = 32'(BUFFER_BYTES - 9);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      sum_reg, sum_next;

    logic [31:0]      byte_shift;
    logic [31:0]      len_merged;
    logic [31:0]      sum_merged;
    logic             count_wrap;
    logic             pay_last;

    assign byte_shift = {24'd0, rx_byte} << {count_reg[1:0], 3'b000};
    assign len_merged = len_reg | byte_shift;
    assign sum_merged = sum_reg | byte_shift;
    assign count_wrap = (count_reg[1:0] == 2'd3);
    // index never reaches the length inside the payload, so equality marks the end
    assign pay_last   = ((count_reg + CNT_W'(1)) == len_reg[CNT_W-1:0]);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte)
                    begin
                        phase_next = PH_LEN;
                        count_next = '0;
                        len_next   = '0;
                        sum_next   = '0;
                    end
                end
                PH_LEN:
                begin
                    len_next   = len_merged;
                    count_next = count_reg + CNT_W'(1);
                    if (count_wrap)
                    begin
                        count_next = '0;
                        if (len_merged > LEN_LIMIT)
                        begin
                            phase_next = PH_HUNT;
                            len_next   = '0;
                            sum_next   = '0;
                        end
                        else if (len_merged == 32'd0)
                            phase_next = PH_SUM;
                        else
                            phase_next = PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (pay_last)
                    begin
                        phase_next = PH_SUM;
                        count_next = '0;
                    end
                end
                PH_SUM:
                begin
                    sum_next   = sum_merged;
                    count_next = count_reg + CNT_W'(1);
                    if (count_wrap)
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        len_next   = '0;
                        sum_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        res.event_kind = EV_DATA;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (count_wrap && (len_merged > LEN_LIMIT))
                    begin
                        res_valid      = 1'b1;
                        res.event_kind = EV_REJECT;
                    end
                end
                PH_PAY:
                begin
                    res_valid        = 1'b1;
                    res.event_kind   = EV_DATA;
                    res.data_byte    = rx_byte;
                    res.byte_index   = IDX_W'(count_reg);
                    res.last_payload = pay_last;
                end
                PH_SUM:
                begin
                    if (count_wrap)
                    begin
                        res_valid          = 1'b1;
                        res.event_kind     = EV_DONE;
                        res.frame_length   = len_reg[FLEN_W-1:0];
                        res.frame_checksum = sum_merged;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

// ===== hw/rtl/length_prefixed_frame_receiver.sv =====
// A result is registered into the output register, or into the skid entry while the output register is held.
// One byte is accepted per cycle while s_tready is high; the phase and counter update on each accepted byte.
// An output register plus one skid entry hold results; s_tready drops only when both are full.
// Reset (rst_n low, asynchronous): start byte 126, hunting, no result pending.
module length_prefixed_frame_receiver #(
    parameter int unsigned BUFFER_BYTES = lpfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lpfr_pkg::TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                                    // [27:18] frame_length,
                                                    // [59:28] frame_checksum, [63:60] zero
    output logic [1:0]                   m_tuser,   // [1:0] event_kind
    output logic                         m_tlast,   // last_payload
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_data   // [7:0] start_byte
);
    import lpfr_pkg::*;

    logic [7:0] start_byte_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    logic       take;

    logic       out_valid_reg;
    result_t    out_reg;
    logic       skid_valid_reg;
    result_t    skid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign take      = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= START_BYTE_RST;
        else if (cfg_valid && cfg_ready)
            start_byte_reg <= cfg_data;
    end

    lpfr_parse #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .start_byte (start_byte_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // no input byte is accepted while the skid entry is full
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tlast  = out_reg.last_payload;
    assign m_tdata  = {4'd0, out_reg.frame_checksum, out_reg.frame_length,
                       out_reg.byte_index, out_reg.data_byte};

endmodule

// ===== hw/rtl/lpfr_checker.sv =====
module lpfr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lpfr_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import lpfr_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != EV_UNUSED)
        else $error("unused event kind");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_DATA |-> !m_tlast)
        else $error("last flag outside payload");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_REJECT |-> m_tdata == '0)
        else $error("reject carries data");

    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_DATA |-> m_tdata[TDATA_W-1:18] == '0)
        else $error("payload item carries frame fields");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/length_prefixed_frame_receiver_test.sv =====
module length_prefixed_frame_receiver_test;
    import lpfr_pkg::*;

    localparam int unsigned MAX_LEN   = BUFFER_BYTES_DEF - 9;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          SETTLE_CYCLES = 4;

    // Predicts the event stream of the deframer and checks it against the DUT.
    class deframe_checker;
        logic [7:0]  start_byte;
        phase_t      stage;
        int unsigned count;
        logic [31:0] length_acc;
        logic [31:0] checksum_acc;
        result_t     pending_events[$];
        int          errors;
        int          bytes_in;
        int          events_checked;
        int          payload_events;
        int          frames_done;
        int          rejects;

        function new();
            start_byte = START_BYTE_RST;
            errors = 0;
            bytes_in = 0;
            events_checked = 0;
            payload_events = 0;
            frames_done = 0;
            rejects = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            stage = PH_HUNT;
            count = 0;
            length_acc = '0;
            checksum_acc = '0;
        endfunction

        function void set_start_byte(logic [7:0] value);
            start_byte = value;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            result_t want;
            bit      last;
            want = '0;
            bytes_in++;
            case (stage)
                PH_HUNT:
                    if (b == start_byte)
                    begin
                        restart_hunt();
                        stage = PH_LEN;
                    end
                PH_LEN:
                begin
                    length_acc |= 32'(b) << (8 * count);
                    count++;
                    if (count == 4)
                    begin
                        count = 0;
                        if (length_acc > MAX_LEN)
                        begin
                            want.event_kind = EV_REJECT;
                            pending_events.push_back(want);
                            rejects++;
                            restart_hunt();
                        end
                        else
                        begin
                            stage = (length_acc == 0) ? PH_SUM : PH_PAY;
                        end
                    end
                end
                PH_PAY:
                begin
                    last = (count + 1) >= length_acc;
                    want.event_kind   = EV_DATA;
                    want.data_byte    = b;
                    want.byte_index   = 10'(count);
                    want.last_payload = last;
                    pending_events.push_back(want);
                    payload_events++;
                    count++;
                    if (last)
                    begin
                        stage = PH_SUM;
                        count = 0;
                    end
                end
                default:
                begin
                    checksum_acc |= 32'(b) << (8 * count);
                    count++;
                    if (count == 4)
                    begin
                        want.event_kind     = EV_DONE;
                        want.frame_length   = length_acc[FLEN_W-1:0];
                        want.frame_checksum = checksum_acc;
                        pending_events.push_back(want);
                        frames_done++;
                        restart_hunt();
                    end
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at event %0d: %s got 0x%0h want 0x%0h",
                     events_checked, what, got, want);
            errors++;
        endtask

        task compare_field(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch(what, got, want);
        endtask

        task check_event(result_t got);
            result_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch("event with nothing pending", 32'(got.event_kind), '0);
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
            compare_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
            compare_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
            compare_field("last_payload", 32'(got.last_payload), 32'(want.last_payload));
            compare_field("frame_length", 32'(got.frame_length), 32'(want.frame_length));
            compare_field("frame_checksum", got.frame_checksum, want.frame_checksum);
            events_checked++;
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data  = '0;

    deframe_checker chk = new();
    result_t        seen_event;
    logic [7:0]     cur_start = START_BYTE_RST;
    int             tx_gap_pct   = 8;
    int             rx_stall_pct = 58;
    int             items_sent   = 0;
    int             idle_cycles  = 0;

    length_prefixed_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= rx_stall_pct);

    // Check results before noting the new byte: results are registered, so they trail their byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_event.event_kind     = event_t'(m_tuser);
                seen_event.data_byte      = m_tdata[7:0];
                seen_event.byte_index     = m_tdata[17:8];
                seen_event.last_payload   = m_tlast;
                seen_event.frame_length   = m_tdata[27:18];
                seen_event.frame_checksum = m_tdata[59:28];
                chk.check_event(seen_event);
            end
            if (cfg_valid && cfg_ready)
                chk.set_start_byte(cfg_data);
            if (s_tvalid && s_tready)
                chk.note_rx_byte(s_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value);
        @(negedge clk);
        // idle each cycle with the sender's gap chance
        while ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender off until every pending event has come out.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (chk.pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cur_start = value;
    endtask

    task automatic send_noise(input int n, input bit avoid_start);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (avoid_start && b == cur_start)
                b ^= 8'h01;
            send_byte(b);
        end
    endtask

    // Payload bytes equal the start byte with the given percent chance.
    task automatic send_frame(input logic [31:0] len_word, input int start_share);
        logic [31:0] sum;
        send_byte(cur_start);
        for (int i = 0; i < 4; i++)
            send_byte(len_word[8*i +: 8]);
        if (len_word <= MAX_LEN)
        begin
            for (int unsigned i = 0; i < len_word; i++)
                send_byte(($urandom_range(99) < start_share) ? cur_start : 8'($urandom));
            sum = $urandom;
            for (int i = 0; i < 4; i++)
                send_byte(sum[8*i +: 8]);
        end
    endtask

    task automatic run_random(input int n_items);
        int          first;
        int          r;
        logic [31:0] len_word;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_noise($urandom_range(1, 4), 1'b1);
            else if (r < 9)
            begin
                // broken frame: start byte and at most six random bytes, too few to finish a frame
                send_byte(cur_start);
                send_noise($urandom_range(1, 6), 1'b0);
            end
            else if (r < 20)
            begin
                case ($urandom_range(3))
                    0:       len_word = MAX_LEN + 1;
                    1:       len_word = 32'hFFFF_FFFF;
                    2:       len_word = $urandom_range(MAX_LEN + 1, 65535);
                    default: len_word = $urandom;
                endcase
                send_frame(len_word, 0);
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 10)
                    len_word = 0;
                else if (r < 85)
                    len_word = $urandom_range(1, 12);
                else
                    len_word = $urandom_range(13, 80);
                send_frame(len_word, ($urandom_range(3) == 0) ? 20 : 0);
                if ($urandom_range(99) < 3)
                    settle();
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: noise, empty frame, rejected length, start byte as payload
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(32'd0, 0);
        send_frame(MAX_LEN + 1, 0);
        // change the start byte in the middle of a frame header
        send_byte(cur_start);
        send_byte(8'h01);
        send_byte(8'h00);
        write_start_byte(8'h5A);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(START_BYTE_RST);
        for (int i = 0; i < 4; i++)
            send_byte(8'hFF);

        write_start_byte(8'h00);
        run_random(200);

        tx_gap_pct   = 58;
        rx_stall_pct = 8;
        write_start_byte(8'hFF);
        run_random(200);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_start_byte(8'($urandom_range(1, 254)));
        run_random(180);
        settle();

        if (chk.pending_events.size() != 0)
            chk.report_mismatch("events never delivered", chk.pending_events.size(), 0);
        $display("sent %0d bytes: %0d payload bytes, %0d frames, %0d rejected lengths",
                 chk.bytes_in, chk.payload_events, chk.frames_done, chk.rejects);
        $display("checked %0d events over five start-byte settings, %0d mismatches",
                 chk.events_checked, chk.errors);
        if (chk.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lpfr_pkg.sv
hw/rtl/lpfr_parse.sv
hw/rtl/length_prefixed_frame_receiver.sv
hw/rtl/lpfr_checker.sv
verif/length_prefixed_frame_receiver_test.sv
